/* src/per_peer_token_bucket_limiter_defines.svh */
// Assertion macros shared by the rate limiter RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef PER_PEER_TOKEN_BUCKET_LIMITER_DEFINES_SVH
`define PER_PEER_TOKEN_BUCKET_LIMITER_DEFINES_SVH

// Property holds on every clock edge out of reset.
`define PPTB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define PPTB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define PPTB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/pptb_pkg.sv */
// Types, constants and bucket tables of the per-peer token bucket limiter.
// No dependencies.
`timescale 1ns / 1ps
package pptb_pkg;

  typedef enum logic [1:0] {
    ACT_CHECK  = 2'd0,
    ACT_RETRY  = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  localparam int TOK_W     = 32;
  localparam int TIME_W    = 48;
  localparam int EL_W      = 25;
  localparam int SCALE_W   = 12;
  localparam int RATE_W    = 14;
  localparam int BURST_W   = 26;
  localparam int RS_W      = RATE_W + SCALE_W;
  localparam int ADD_W     = RS_W + EL_W - 8;
  localparam int COST_W    = 20;
  localparam int Q_W       = 11;
  localparam int SLOTS     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int DX_W      = 18;
  localparam int DMUL_W    = 19;

  localparam logic CFG_MAX_PEERS = 1'b0;
  localparam logic CFG_SCALE     = 1'b1;

  localparam logic [EL_W-1:0] EL_CLAMP = 25'h1000000;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd256;

  // micro-tokens per ms, burst and cost in micro-tokens
  localparam logic [RATE_W-1:0] RATE_UPMS [SLOTS] = '{
    14'd5000, 14'd500, 14'd1000, 14'd10000, 14'd10000, 14'd10000, 14'd10000, 14'd10000};
  localparam logic [BURST_W-1:0] BURST_UT [SLOTS] = '{
    26'd50000000, 26'd5000000, 26'd10000000, 26'd10000000,
    26'd10000000, 26'd10000000, 26'd10000000, 26'd10000000};
  localparam logic [COST_W-1:0] COST_UT [SLOTS] = '{
    20'd1000000, 20'd1000000, 20'd1000000, 20'd100000,
    20'd100000, 20'd100000, 20'd100000, 20'd100000};

  // rate = 2^pre * 125 or 2^pre * 625; deficit >> pre stays below 2^18,
  // where (x * mul) >> post is exactly x / (rate >> pre)
  localparam logic [2:0] DIV_PRE [SLOTS] = '{
    3'd3, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4};
  localparam logic [DMUL_W-1:0] DIV_MUL [SLOTS] = '{
    19'd429497, 19'd268436, 19'd268436, 19'd429497,
    19'd429497, 19'd429497, 19'd429497, 19'd429497};
  localparam logic [4:0] DIV_POST [SLOTS] = '{
    5'd28, 5'd25, 5'd25, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28};

  // burst * scale / 256 stays below 2^30, no saturation needed
  function automatic logic [TOK_W-1:0] scaled_burst(input logic [2:0] t,
                                                    input logic [SCALE_W-1:0] s);
    logic [BURST_W+SCALE_W-1:0] p;
    p = BURST_UT[t] * s;
    return TOK_W'(p >> 8);
  endfunction

endpackage

/* src/pptb_row_ram.sv */
// Peer table memory: one row per peer (key, tokens, last refill times).
// Synchronous read, data registered the cycle after rd_en_i. Depends on nothing.
`timescale 1ns / 1ps
module pptb_row_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 464
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

/* src/pptb_div.sv */
// Retry time divider: deficit / rate by a shift and a reciprocal multiply;
// operands are registered at start, then quotient and done_o. Depends on pptb_pkg.
`timescale 1ns / 1ps
module pptb_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pptb_pkg::COST_W-1:0]  dividend_i,
  input  logic [2:0]                   type_i,
  output logic                         done_o,
  output logic [pptb_pkg::Q_W-1:0]     quotient_o
);

  localparam int P_W = pptb_pkg::DX_W + pptb_pkg::DMUL_W;

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [pptb_pkg::DX_W-1:0]    x_q, x_d;
  logic [pptb_pkg::DMUL_W-1:0]  mul_q, mul_d;
  logic [4:0]                   post_q, post_d;
  logic [pptb_pkg::Q_W-1:0]     quo_q, quo_d;
  logic [P_W-1:0]               prod;
  logic [P_W-1:0]               shifted;

  always_comb begin
    busy_d  = start_i;
    done_d  = busy_q;
    x_d     = x_q;
    mul_d   = mul_q;
    post_d  = post_q;
    quo_d   = quo_q;
    prod    = P_W'(x_q) * P_W'(mul_q);
    shifted = prod >> post_q;
    if (start_i) begin
      x_d    = pptb_pkg::DX_W'(dividend_i >> pptb_pkg::DIV_PRE[type_i]);
      mul_d  = pptb_pkg::DIV_MUL[type_i];
      post_d = pptb_pkg::DIV_POST[type_i];
    end
    if (busy_q) begin
      quo_d = pptb_pkg::Q_W'(shifted);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    mul_q  <= mul_d;
    post_q <= post_d;
    quo_q  <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* src/per_peer_token_bucket_limiter.sv */
// Per-peer token bucket rate limiter, top level.
// Depends on pptb_pkg, pptb_row_ram, pptb_div and the defines header.
// Input channel s_axis: one item per request. tuser carries the action
// (check, retry query, remove); tdata carries key, request type and time.
// Output channel m_axis: exactly one result item per input item, in order.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 peer cap,
// 1 Q4.8 scale) and cfg_data_i; always ready.
// The peer table lives in one row memory; every item scans the live rows
// (one row a cycle), then a check reads, modifies and writes back the
// peer's row. Removal and eviction copy each following row down, one a
// cycle.
// One item is in work at a time; the next item is taken as soon as the
// result sits in the output register, even if it is not yet taken.
// Reset empties the table at once (count cleared), cap ENTRIES, scale 256.
// A stalled receiver holds the result; the following item then waits in
// its final state until the output register frees.
`timescale 1ns / 1ps
`include "per_peer_token_bucket_limiter_defines.svh"
module per_peer_token_bucket_limiter #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64,
  parameter int TYPES    = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // peer_key[63:0], rpc_type[66:64], now_ms[114:67], zero pad
  input  logic [119:0]                     s_axis_tdata,
  // action[1:0]
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // accepted[0], retry_after_ms[32:1], peer_found[33], evicted[34], zero pad
  output logic [39:0]                      m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pptb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pptb_pkg::SCALE_W-1:0]     cfg_data_i
);

  localparam int CW       = $clog2(ENTRIES + 1);
  localparam int AW       = $clog2(ENTRIES);
  localparam int TOK_W    = pptb_pkg::TOK_W;
  localparam int TIME_W   = pptb_pkg::TIME_W;
  localparam int TOK_OFS  = KEY_BITS;
  localparam int LAST_OFS = KEY_BITS + TYPES * TOK_W;
  localparam int ROW_W    = LAST_OFS + TYPES * TIME_W;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_SCAN   = 12'b000000000010,
    S_DECIDE = 12'b000000000100,
    S_SHIFT  = 12'b000000001000,
    S_APPEND = 12'b000000010000,
    S_RD     = 12'b000000100000,
    S_MOD1   = 12'b000001000000,
    S_MOD2   = 12'b000010000000,
    S_MOD3   = 12'b000100000000,
    S_RET    = 12'b001000000000,
    S_DIV    = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]                       max_peers_q;
  logic [pptb_pkg::SCALE_W-1:0]     scale_q;

  pptb_pkg::action_e                act_q, act_d;
  logic [KEY_BITS-1:0]              key_q, key_d;
  logic [2:0]                       type_q, type_d;
  logic [TIME_W-1:0]                now_q, now_d;
  logic [pptb_pkg::RS_W-1:0]        rs_q, rs_d;
  logic [TOK_W-1:0]                 capb_q, capb_d;
  logic [CW-1:0]                    count_q, count_d;
  logic [CW-1:0]                    ptr_q, ptr_d;
  logic                             pend_q, pend_d;
  logic [CW-1:0]                    pidx_q, pidx_d;
  logic                             found_q, found_d;
  logic [AW-1:0]                    fidx_q, fidx_d;
  logic [TIME_W-1:0]                min_q, min_d;
  logic [AW-1:0]                    minidx_q, minidx_d;
  logic                             ev_q, ev_d;
  logic [AW-1:0]                    e_q, e_d;
  logic                             acc_q, acc_d;
  logic [31:0]                      retry_q, retry_d;
  logic [ROW_W-1:0]                 row_q, row_d;
  logic [TOK_W-1:0]                 tok_q, tok_d;
  logic                             never_q, never_d;
  logic                             same_q, same_d;
  logic [pptb_pkg::EL_W-1:0]        el_q, el_d;
  logic [pptb_pkg::ADD_W-1:0]       add_q, add_d;
  logic                             out_valid_q, out_valid_d;
  logic [39:0]                      out_data_q, out_data_d;

  logic                             mem_re, mem_we;
  logic [AW-1:0]                    mem_ra, mem_wa;
  logic [ROW_W-1:0]                 mem_rd, mem_wd;

  logic                             div_start, div_done;
  logic [pptb_pkg::COST_W-1:0]      div_num;
  logic [pptb_pkg::Q_W-1:0]         div_quo;

  logic                             s_acc;
  logic                             type_ok;
  logic [CW-1:0]                    cap;
  logic [TOK_W-1:0]                 sel_tok;
  logic [TIME_W-1:0]                sel_last;
  logic [TIME_W-1:0]                diff;
  logic [ROW_W-1:0]                 new_row;
  logic [ROW_W-1:0]                 upd_row;
  logic [pptb_pkg::ADD_W:0]         sum;
  logic [TOK_W-1:0]                 tok_new;
  logic [TOK_W-1:0]                 tok_fin;
  logic                             admit;
  logic [CW-1:0]                    wa_full;
  logic [pptb_pkg::RS_W+pptb_pkg::EL_W-1:0] prod;
  logic [pptb_pkg::COST_W-1:0]      cost;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign type_ok       = (32'(type_q) < 32'(TYPES));
  assign cost          = pptb_pkg::COST_UT[type_q];

  always_comb begin
    if (max_peers_q != 5'd0 && 32'(max_peers_q) <= 32'(ENTRIES)) begin
      cap = CW'(max_peers_q);
    end else begin
      cap = CW'(ENTRIES);
    end
  end

  // bucket of the current type inside the row just read
  always_comb begin
    sel_tok  = '0;
    sel_last = '0;
    for (int t = 0; t < TYPES; t++) begin
      if (type_q == 3'(t)) begin
        sel_tok  = mem_rd[TOK_OFS + t*TOK_W +: TOK_W];
        sel_last = mem_rd[LAST_OFS + t*TIME_W +: TIME_W];
      end
    end
  end

  // fresh row: every bucket full, never refilled
  always_comb begin
    new_row = '0;
    new_row[KEY_BITS-1:0] = key_q;
    for (int t = 0; t < TYPES; t++) begin
      new_row[TOK_OFS + t*TOK_W +: TOK_W] = pptb_pkg::scaled_burst(3'(t), scale_q);
    end
  end

  assign diff = now_q - sel_last;
  assign prod = rs_q * el_q;
  assign sum  = (pptb_pkg::ADD_W+1)'(tok_q) + (pptb_pkg::ADD_W+1)'(add_q);

  always_comb begin
    if (never_q || same_q) begin
      tok_new = tok_q;
    end else if (sum > (pptb_pkg::ADD_W+1)'(capb_q)) begin
      tok_new = capb_q;
    end else begin
      tok_new = TOK_W'(sum);
    end
    admit   = (tok_new >= TOK_W'(cost));
    tok_fin = admit ? tok_new - TOK_W'(cost) : tok_new;
    upd_row = row_q;
    for (int t = 0; t < TYPES; t++) begin
      if (type_q == 3'(t)) begin
        upd_row[TOK_OFS + t*TOK_W +: TOK_W] = tok_fin;
        if (!same_q) begin
          upd_row[LAST_OFS + t*TIME_W +: TIME_W] = now_q;
        end
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    key_d       = key_q;
    type_d      = type_q;
    now_d       = now_q;
    rs_d        = rs_q;
    capb_d      = capb_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    pidx_d      = ptr_q;
    found_d     = found_q;
    fidx_d      = fidx_q;
    min_d       = min_q;
    minidx_d    = minidx_q;
    ev_d        = ev_q;
    e_d         = e_q;
    acc_d       = acc_q;
    retry_d     = retry_q;
    row_d       = row_q;
    tok_d       = tok_q;
    never_d     = never_q;
    same_d      = same_q;
    el_d        = el_q;
    add_d       = add_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    mem_re      = 1'b0;
    mem_ra      = ptr_q[AW-1:0];
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = mem_rd;
    div_start   = 1'b0;
    div_num     = '0;
    wa_full     = pidx_q - CW'(1);

    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          act_d   = pptb_pkg::action_e'(s_axis_tuser);
          key_d   = s_axis_tdata[KEY_BITS-1:0];
          type_d  = s_axis_tdata[66:64];
          now_d   = s_axis_tdata[114:67];
          rs_d    = pptb_pkg::RATE_UPMS[s_axis_tdata[66:64]] * scale_q;
          capb_d  = pptb_pkg::scaled_burst(s_axis_tdata[66:64], scale_q);
          ptr_d   = '0;
          found_d = 1'b0;
          ev_d    = 1'b0;
          acc_d   = 1'b0;
          retry_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        mem_re = (ptr_q < count_q);
        pend_d = mem_re;
        if (mem_re) begin
          ptr_d = ptr_q + CW'(1);
        end
        if (pend_q) begin
          if (mem_rd[KEY_BITS-1:0] == key_q && !found_q) begin
            found_d = 1'b1;
            fidx_d  = pidx_q[AW-1:0];
          end
          // oldest type-0 refill; strict compare keeps the earliest entry
          if (pidx_q == '0 || mem_rd[LAST_OFS +: TIME_W] < min_q) begin
            min_d    = mem_rd[LAST_OFS +: TIME_W];
            minidx_d = pidx_q[AW-1:0];
          end
        end
        if (!pend_q && !mem_re) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (act_q)
          pptb_pkg::ACT_CHECK: begin
            if (!type_ok) begin
              state_d = S_DONE;
            end else if (found_q) begin
              e_d     = fidx_q;
              state_d = S_RD;
            end else if (count_q >= cap) begin
              ev_d    = 1'b1;
              ptr_d   = CW'(minidx_q) + CW'(1);
              state_d = S_SHIFT;
            end else begin
              state_d = S_APPEND;
            end
          end
          pptb_pkg::ACT_RETRY: begin
            if (type_ok && found_q) begin
              e_d     = fidx_q;
              state_d = S_RD;
            end else begin
              state_d = S_DONE;
            end
          end
          pptb_pkg::ACT_REMOVE: begin
            if (found_q) begin
              ptr_d   = CW'(fidx_q) + CW'(1);
              state_d = S_SHIFT;
            end else begin
              state_d = S_DONE;
            end
          end
          default: begin
            found_d = 1'b0;
            state_d = S_DONE;
          end
        endcase
      end
      S_SHIFT: begin
        // row i+1 read this cycle is written to row i the next
        mem_re = (ptr_q < count_q);
        pend_d = mem_re;
        if (mem_re) begin
          ptr_d = ptr_q + CW'(1);
        end
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = wa_full[AW-1:0];
          mem_wd = mem_rd;
        end
        if (!pend_q && !mem_re) begin
          count_d = count_q - CW'(1);
          state_d = (act_q == pptb_pkg::ACT_CHECK) ? S_APPEND : S_DONE;
        end
      end
      S_APPEND: begin
        mem_we  = 1'b1;
        mem_wa  = count_q[AW-1:0];
        mem_wd  = new_row;
        e_d     = count_q[AW-1:0];
        count_d = count_q + CW'(1);
        state_d = S_RD;
      end
      S_RD: begin
        mem_re  = 1'b1;
        mem_ra  = e_q;
        state_d = (act_q == pptb_pkg::ACT_CHECK) ? S_MOD1 : S_RET;
      end
      S_MOD1: begin
        row_d   = mem_rd;
        tok_d   = sel_tok;
        never_d = (sel_last == '0);
        same_d  = (sel_last != '0) && (diff == '0);
        el_d    = (diff > TIME_W'(pptb_pkg::EL_CLAMP)) ? pptb_pkg::EL_CLAMP
                                                      : pptb_pkg::EL_W'(diff);
        state_d = S_MOD2;
      end
      S_MOD2: begin
        add_d   = prod[pptb_pkg::RS_W+pptb_pkg::EL_W-1:8];
        state_d = S_MOD3;
      end
      S_MOD3: begin
        mem_we  = 1'b1;
        mem_wa  = e_q;
        mem_wd  = upd_row;
        acc_d   = admit;
        state_d = S_DONE;
      end
      S_RET: begin
        if (sel_tok >= TOK_W'(cost)) begin
          state_d = S_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = cost - pptb_pkg::COST_W'(sel_tok);
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          retry_d = 32'(div_quo);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'd0, ev_q, found_q, retry_q, acc_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      max_peers_q <= '0;
      scale_q     <= pptb_pkg::SCALE_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == pptb_pkg::CFG_MAX_PEERS) begin
          max_peers_q <= cfg_data_i[4:0];
        end else begin
          scale_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    key_q      <= key_d;
    type_q     <= type_d;
    now_q      <= now_d;
    rs_q       <= rs_d;
    capb_q     <= capb_d;
    ptr_q      <= ptr_d;
    pidx_q     <= pidx_d;
    found_q    <= found_d;
    fidx_q     <= fidx_d;
    min_q      <= min_d;
    minidx_q   <= minidx_d;
    ev_q       <= ev_d;
    e_q        <= e_d;
    acc_q      <= acc_d;
    retry_q    <= retry_d;
    row_q      <= row_d;
    tok_q      <= tok_d;
    never_q    <= never_d;
    same_q     <= same_d;
    el_q       <= el_d;
    add_q      <= add_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  pptb_row_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_ra),
    .rd_data_o (mem_rd),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_wa),
    .wr_data_i (mem_wd)
  );

  pptb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .type_i     (type_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  `PPTB_ASSERT(a_count_max, count_q <= CW'(ENTRIES))
  `PPTB_ASSERT_IMPL(a_we_states, mem_we, (state_q == S_SHIFT) || (state_q == S_APPEND) || (state_q == S_MOD3))
  `PPTB_ASSERT_IMPL(a_evict_new_peer, m_axis_tvalid && m_axis_tdata[34], !m_axis_tdata[33])
  `PPTB_ASSERT_NEXT(a_append_grows, state_q == S_APPEND, count_q == $past(count_q) + CW'(1))

endmodule
